FILE: rtl/dfma_pkg.sv
package dfma_pkg;

	localparam int EXP_W = 14;

	localparam logic [10:0] EXP_ALL_ONES = 11'h7ff;
	localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
	localparam logic [63:0] INF_BITS = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] MAX_FINITE_BITS = 64'h7FEF_FFFF_FFFF_FFFF;

	localparam logic [1:0] RM_RNE = 2'd0;
	localparam logic [1:0] RM_RTZ = 2'd1;
	localparam logic [1:0] RM_RUP = 2'd2;
	localparam logic [1:0] RM_RDN = 2'd3;

	localparam int FLAG_INV = 0;
	localparam int FLAG_OVF = 1;
	localparam int FLAG_UNF = 2;
	localparam int FLAG_INX = 3;

	typedef logic signed [EXP_W-1:0] exp_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic        spec;
		logic [63:0] spec_res;
		logic [3:0]  spec_flags;
	} ctl_t;

	typedef struct packed {
		logic [52:0] m;
		exp_t        e;
	} unpacked_t;

	function automatic logic [5:0] lzc53(input logic [52:0] v);
		logic [5:0] cnt;
		cnt = 6'd53;
		for (int i = 0; i < 53; i++) begin
			if (v[i]) cnt = 6'(52 - i);
		end
		return cnt;
	endfunction

	function automatic logic [7:0] lzc128(input logic [127:0] v);
		logic [7:0] cnt;
		cnt = 8'd128;
		for (int i = 0; i < 128; i++) begin
			if (v[i]) cnt = 8'(127 - i);
		end
		return cnt;
	endfunction

	function automatic unpacked_t unpack(input logic [63:0] b);
		unpacked_t  r;
		logic [52:0] m0;
		logic [5:0]  lz;
		m0 = {1'b0, b[51:0]};
		lz = lzc53(m0);
		if (b[62:52] != 11'd0) begin
			r.m = {1'b1, b[51:0]};
			r.e = $signed({3'b000, b[62:52]});
		end else begin
			r.m = m0 << lz;
			r.e = exp_t'(1) - $signed({8'd0, lz});
		end
		return r;
	endfunction

	function automatic logic round_inc(input logic [1:0] mode, input logic rb, input logic sb,
			input logic lsb, input logic neg);
		logic inc;
		case (mode)
			RM_RNE: inc = rb & (sb | lsb);
			RM_RTZ: inc = 1'b0;
			RM_RUP: inc = (rb | sb) & ~neg;
			RM_RDN: inc = (rb | sb) & neg;
			default: inc = 1'b0;
		endcase
		return inc;
	endfunction

endpackage

FILE: rtl/dfma_if.sv
interface dfma_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] mul_a_bits;
	logic [63:0] mul_b_bits;
	logic [63:0] addend_bits;

	modport source(output valid, output mul_a_bits, output mul_b_bits, output addend_bits,
		input ready);
	modport sink(input valid, input mul_a_bits, input mul_b_bits, input addend_bits,
		output ready);
endinterface

interface dfma_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] sum_bits;
	logic [3:0]  exception_flags;

	modport source(output valid, output sum_bits, output exception_flags, input ready);
	modport sink(input valid, input sum_bits, input exception_flags, output ready);
endinterface

FILE: rtl/double_fused_multiply_add.sv
// Binary64 fused multiply-add: sum_bits = mul_a_bits * mul_b_bits + addend_bits, rounded once.
// A request enters on in_req (valid/ready) carrying the two factors and the addend; the
// result and its exception flags (invalid, overflow, underflow, inexact) leave on out_res.
// The rounding mode is written through cfg_we and cfg_wdata; the user must do so only while no
// request is in flight, as the block does not enforce it. The datapath is a nine-stage pipeline:
// unpack, partial products, product sum and exponent difference, alignment, add or subtract,
// leading-zero count, normalisation, denormal shift, and rounding into the output register.
// One request is accepted every cycle while the receiver takes results.
// When the receiver stalls, the whole pipeline holds and in_req.ready falls, so nothing is
// lost or repeated; bubbles in the pipeline are not squeezed out.
// Reset clears all pipeline valid bits and sets the rounding mode to nearest-even.
// Every NaN result is the canonical quiet NaN.
module double_fused_multiply_add
	import dfma_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	dfma_in_if.sink    in_req,
	dfma_out_if.source out_res
);

	logic [1:0] mode_q;
	logic advance;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7, ctl_s8;

	// Stage 1
	logic [52:0] ma_s1, mb_s1, mz_s1;
	exp_t        ea_s1, eb_s1, ez_s1;
	logic        sp_s1, zs_s1, zzero_s1;
	// Stage 2
	logic [53:0] pll_s2, plh_s2, phl_s2, phh_s2;
	exp_t        ep_s2, ez_s2;
	logic [52:0] mz_s2;
	logic        sp_s2, zs_s2, zzero_s2;
	// Stage 3
	logic [105:0] prod_s3;
	logic [52:0]  mz_s3;
	exp_t         e_s3;
	logic         pge_s3, sp_s3, zs_s3;
	logic [7:0]   sh_s3;
	// Stage 4
	logic [127:0] pa_s4, za_s4;
	exp_t         e_s4;
	logic         st_s4, sp_s4, zs_s4;
	// Stage 5
	logic [127:0] r_s5;
	exp_t         e_s5;
	logic         st_s5, sign_s5;
	// Stage 6
	logic [127:0] r_s6;
	logic [7:0]   lz_s6;
	exp_t         e_s6;
	logic         st_s6, sign_s6, zero_s6;
	// Stage 7
	logic [127:0] n_s7;
	exp_t         be_s7;
	logic [5:0]   k_s7;
	logic         norm_s7, st_s7, sign_s7, zero_s7;
	// Stage 8
	logic [52:0]  kept_s8;
	logic         rb_s8, sb_s8, untiny_s8, norm_s8, sign_s8, zero_s8;
	exp_t         be_s8;
	// Stage 9
	logic [63:0]  sum_s9;
	logic [3:0]   flags_s9;

	assign advance = ~v_s9 | out_res.ready;
	assign in_req.ready = advance;
	assign out_res.valid = v_s9;
	assign out_res.sum_bits = sum_s9;
	assign out_res.exception_flags = flags_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= RM_RNE;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// Stage 1: classification, special results and unpacking.
	logic [63:0] x, y, z;
	logic        xs, ys, zs, sp;
	logic        xnan, ynan, znan, xinf, yinf, zinf, xzero, yzero, zzero, inv;
	ctl_t        ctl_d1;
	unpacked_t   ux, uy, uz;

	always_comb begin
		x = in_req.mul_a_bits;
		y = in_req.mul_b_bits;
		z = in_req.addend_bits;
		xs = x[63];
		ys = y[63];
		zs = z[63];
		sp = xs ^ ys;
		xnan = (x[62:52] == EXP_ALL_ONES) && (x[51:0] != 52'd0);
		ynan = (y[62:52] == EXP_ALL_ONES) && (y[51:0] != 52'd0);
		znan = (z[62:52] == EXP_ALL_ONES) && (z[51:0] != 52'd0);
		xinf = (x[62:52] == EXP_ALL_ONES) && (x[51:0] == 52'd0);
		yinf = (y[62:52] == EXP_ALL_ONES) && (y[51:0] == 52'd0);
		zinf = (z[62:52] == EXP_ALL_ONES) && (z[51:0] == 52'd0);
		xzero = (x[62:0] == 63'd0);
		yzero = (y[62:0] == 63'd0);
		zzero = (z[62:0] == 63'd0);
		inv = (xnan & ~x[51]) | (ynan & ~y[51]) | (znan & ~z[51]) |
			(xinf & yzero) | (yinf & xzero);
		ctl_d1.mode = mode_q;
		ctl_d1.spec = 1'b1;
		ctl_d1.spec_res = QNAN_BITS;
		ctl_d1.spec_flags = 4'd0;
		if (xnan || ynan || znan || inv) begin
			ctl_d1.spec_res = QNAN_BITS;
		end else if (xinf || yinf) begin
			if (zinf && (zs != sp)) begin
				inv = 1'b1;
				ctl_d1.spec_res = QNAN_BITS;
			end else begin
				ctl_d1.spec_res = INF_BITS | {sp, 63'd0};
			end
		end else if (zinf) begin
			ctl_d1.spec_res = z;
		end else if (xzero || yzero) begin
			if (zzero) begin
				ctl_d1.spec_res = {((sp == zs) ? sp : (mode_q == RM_RDN)), 63'd0};
			end else begin
				ctl_d1.spec_res = z;
			end
		end else begin
			ctl_d1.spec = 1'b0;
		end
		ctl_d1.spec_flags[FLAG_INV] = inv;
		ux = unpack(x);
		uy = unpack(y);
		uz = unpack(z);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ctl_s1 <= ctl_d1;
			ma_s1 <= ux.m;
			mb_s1 <= uy.m;
			mz_s1 <= uz.m;
			ea_s1 <= ux.e;
			eb_s1 <= uy.e;
			ez_s1 <= uz.e;
			sp_s1 <= sp;
			zs_s1 <= zs;
			zzero_s1 <= zzero;
		end
	end

	// Stage 2: four partial products of the significands.
	always_ff @(posedge clk) begin
		if (advance) begin
			ctl_s2 <= ctl_s1;
			pll_s2 <= 54'(ma_s1[26:0] * mb_s1[26:0]);
			plh_s2 <= 54'(ma_s1[26:0] * mb_s1[52:27]);
			phl_s2 <= 54'(ma_s1[52:27] * mb_s1[26:0]);
			phh_s2 <= 54'(ma_s1[52:27] * mb_s1[52:27]);
			ep_s2 <= ea_s1 + eb_s1 - exp_t'(2171);
			ez_s2 <= ez_s1 - exp_t'(1149);
			mz_s2 <= mz_s1;
			sp_s2 <= sp_s1;
			zs_s2 <= zs_s1;
			zzero_s2 <= zzero_s1;
		end
	end

	// Stage 3: product sum and exponent difference.
	exp_t       diff, mag;
	logic [7:0] sh_d3;

	always_comb begin
		diff = ep_s2 - ez_s2;
		mag = (diff < 0) ? -diff : diff;
		sh_d3 = (mag >= exp_t'(128)) ? 8'd128 : mag[7:0];
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ctl_s3 <= ctl_s2;
			prod_s3 <= ({52'd0, phh_s2} << 54) + ({52'd0, plh_s2} << 27) +
				({52'd0, phl_s2} << 27) + {52'd0, pll_s2};
			mz_s3 <= zzero_s2 ? 53'd0 : mz_s2;
			if (zzero_s2) begin
				e_s3 <= ep_s2;
				pge_s3 <= 1'b1;
				sh_s3 <= 8'd0;
			end else begin
				e_s3 <= (diff >= 0) ? ep_s2 : ez_s2;
				pge_s3 <= (diff >= 0);
				sh_s3 <= sh_d3;
			end
			sp_s3 <= sp_s2;
			zs_s3 <= zs_s2;
		end
	end

	// Stage 4: align the smaller term, gathering shifted-out bits into the sticky bit.
	logic [127:0] pw, zw, src, shifted;
	logic         lost;

	always_comb begin
		pw = {1'b0, prod_s3, 21'd0};
		zw = {1'b0, mz_s3, 74'd0};
		src = pge_s3 ? zw : pw;
		shifted = src >> sh_s3;
		lost = |(src & ~({128{1'b1}} << sh_s3));
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ctl_s4 <= ctl_s3;
			pa_s4 <= pge_s3 ? pw : shifted;
			za_s4 <= pge_s3 ? shifted : zw;
			st_s4 <= lost;
			e_s4 <= e_s3;
			sp_s4 <= sp_s3;
			zs_s4 <= zs_s3;
		end
	end

	// Stage 5: add or subtract by sign; a sticky tail borrows one from a nonzero difference.
	logic         lt, eq;
	logic [127:0] big, small_t, r_d5;

	always_comb begin
		lt = pa_s4 < za_s4;
		eq = pa_s4 == za_s4;
		big = lt ? za_s4 : pa_s4;
		small_t = lt ? pa_s4 : za_s4;
		if (sp_s4 == zs_s4) begin
			r_d5 = pa_s4 + za_s4;
		end else if (eq) begin
			r_d5 = 128'd0;
		end else begin
			r_d5 = big - small_t - {127'd0, st_s4};
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ctl_s5 <= ctl_s4;
			r_s5 <= r_d5;
			e_s5 <= e_s4;
			st_s5 <= st_s4;
			sign_s5 <= ((sp_s4 != zs_s4) && lt) ? zs_s4 : sp_s4;
		end
	end

	// Stage 6: leading-zero count.
	always_ff @(posedge clk) begin
		if (advance) begin
			ctl_s6 <= ctl_s5;
			r_s6 <= r_s5;
			lz_s6 <= lzc128(r_s5);
			zero_s6 <= (r_s5 == 128'd0);
			e_s6 <= e_s5;
			st_s6 <= st_s5;
			sign_s6 <= sign_s5;
		end
	end

	// Stage 7: normalise so that the leading one sits at the top, and find the denormal shift.
	exp_t be_d7, onemb;

	always_comb begin
		be_d7 = e_s6 + exp_t'(1150) - $signed({6'd0, lz_s6});
		onemb = exp_t'(1) - be_d7;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ctl_s7 <= ctl_s6;
			n_s7 <= r_s6 << lz_s6[6:0];
			be_s7 <= be_d7;
			norm_s7 <= (be_d7 >= exp_t'(1));
			if (be_d7 >= exp_t'(1)) begin
				k_s7 <= 6'd0;
			end else if (onemb > exp_t'(54)) begin
				k_s7 <= 6'd54;
			end else begin
				k_s7 <= onemb[5:0];
			end
			st_s7 <= st_s6;
			sign_s7 <= sign_s6;
			zero_s7 <= zero_s6;
		end
	end

	// Stage 8: denormal shift and round/sticky extraction.
	logic [127:0] n2;
	logic         sk, inc0;

	always_comb begin
		n2 = n_s7 >> k_s7;
		sk = |(n_s7 & ~({128{1'b1}} << k_s7));
		inc0 = round_inc(ctl_s7.mode, n_s7[74], (|n_s7[73:0]) | st_s7, 1'b1, sign_s7);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ctl_s8 <= ctl_s7;
			kept_s8 <= n2[127:75];
			rb_s8 <= n2[74];
			sb_s8 <= (|n2[73:0]) | sk | st_s7;
			untiny_s8 <= (be_s7 == exp_t'(0)) && (&n_s7[127:75]) && inc0;
			norm_s8 <= norm_s7;
			be_s8 <= be_s7;
			sign_s8 <= sign_s7;
			zero_s8 <= zero_s7;
		end
	end

	// Stage 9: rounding and packing into the output register.
	logic        inc, inex, to_inf;
	logic [53:0] sum54;
	logic [52:0] kf;
	exp_t        bef;
	logic [63:0] res_d9;
	logic [3:0]  flags_d9;

	always_comb begin
		inc = round_inc(ctl_s8.mode, rb_s8, sb_s8, kept_s8[0], sign_s8);
		inex = rb_s8 | sb_s8;
		sum54 = {1'b0, kept_s8} + {53'd0, inc};
		kf = sum54[53] ? sum54[53:1] : sum54[52:0];
		bef = be_s8 + $signed({13'd0, sum54[53]});
		to_inf = (ctl_s8.mode == RM_RNE) || ((ctl_s8.mode == RM_RUP) && !sign_s8) ||
			((ctl_s8.mode == RM_RDN) && sign_s8);
		res_d9 = 64'd0;
		flags_d9 = 4'd0;
		if (ctl_s8.spec) begin
			res_d9 = ctl_s8.spec_res;
			flags_d9 = ctl_s8.spec_flags;
		end else if (zero_s8) begin
			res_d9 = {(ctl_s8.mode == RM_RDN), 63'd0};
		end else if (norm_s8) begin
			if (bef >= exp_t'(2047)) begin
				res_d9 = (to_inf ? INF_BITS : MAX_FINITE_BITS) | {sign_s8, 63'd0};
				flags_d9[FLAG_OVF] = 1'b1;
				flags_d9[FLAG_INX] = 1'b1;
			end else begin
				res_d9 = {sign_s8, bef[10:0], kf[51:0]};
				flags_d9[FLAG_INX] = inex;
			end
		end else begin
			res_d9 = {sign_s8, 10'd0, sum54[52:0]};
			flags_d9[FLAG_UNF] = inex & ~untiny_s8;
			flags_d9[FLAG_INX] = inex;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sum_s9 <= res_d9;
			flags_s9 <= flags_d9;
		end
	end

	a_nan_canonical: assert property (@(posedge clk) disable iff (!arst_n)
		(out_res.valid && (out_res.sum_bits[62:52] == EXP_ALL_ONES) &&
		(out_res.sum_bits[51:0] != 52'd0)) |-> (out_res.sum_bits == QNAN_BITS))
		else $error("NaN result is not the canonical quiet NaN");

	a_unf_inexact: assert property (@(posedge clk) disable iff (!arst_n)
		(out_res.valid && out_res.exception_flags[FLAG_UNF]) |->
		out_res.exception_flags[FLAG_INX])
		else $error("Underflow raised without inexact");

	a_ovf_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_res.valid && out_res.exception_flags[FLAG_OVF]) |->
		(out_res.exception_flags[FLAG_INX] &&
		((out_res.sum_bits[62:0] == INF_BITS[62:0]) ||
		(out_res.sum_bits[62:0] == MAX_FINITE_BITS[62:0]))))
		else $error("Overflow result is neither infinity nor the largest finite number");

endmodule

FILE: tb/tb_top.sv
module tb_top
	import dfma_pkg::*;
;

	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_PER_MODE = 340;
	localparam int DRAIN_CYCLES = 16;

	typedef struct {
		logic [63:0] sum_bits;
		logic [3:0]  exception_flags;
	} fma_result_t;

	typedef struct {
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] c;
		bit          known;
		logic [63:0] sum_bits;
		logic [3:0]  exception_flags;
	} fma_vector_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_wdata;
	logic [1:0] active_mode;
	int failures;
	int cycle_count;
	int stall_left;
	fma_result_t pending_sums[$];

	dfma_in_if in_req();
	dfma_out_if out_res();

	double_fused_multiply_add dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_req(in_req.sink),
		.out_res(out_res.source)
	);

	fma_vector_t directed_vectors [0:21] = '{
		'{64'h7FF8000000000000, 64'h3FF0000000000000, 64'h0, 1, QNAN_BITS, 4'b0000},
		'{64'h7FF0000000000001, 64'h3FF0000000000000, 64'h0, 1, QNAN_BITS, 4'b0001},
		'{64'h3FF0000000000000, 64'h3FF0000000000000, 64'hFFF0000000000001, 1, QNAN_BITS, 4'b0001},
		'{64'h7FF0000000000000, 64'h0, 64'h7FF8000000000000, 1, QNAN_BITS, 4'b0001},
		'{64'h7FF0000000000000, 64'h3FF0000000000000, 64'hFFF0000000000000, 1, QNAN_BITS, 4'b0001},
		'{64'h7FF0000000000000, 64'h4000000000000000, 64'h3FF0000000000000, 1, INF_BITS, 4'b0000},
		'{64'hFFF0000000000000, 64'h4000000000000000, 64'h4014000000000000, 1,
			64'hFFF0000000000000, 4'b0000},
		'{64'h3FF0000000000000, 64'h3FF0000000000000, 64'h7FF0000000000000, 1, INF_BITS, 4'b0000},
		'{64'h0, 64'h4014000000000000, 64'h4008000000000000, 1, 64'h4008000000000000, 4'b0000},
		'{64'h3FF0000000000000, 64'h3FF0000000000000, 64'h0, 1, 64'h3FF0000000000000, 4'b0000},
		'{64'h4000000000000000, 64'h4008000000000000, 64'h3FF0000000000000, 1,
			64'h401C000000000000, 4'b0000},
		'{64'h0, 64'h3FF0000000000000, 64'h8000000000000000, 0, 64'h0, 4'b0},
		'{64'h8000000000000000, 64'h3FF0000000000000, 64'h8000000000000000, 0, 64'h0, 4'b0},
		'{64'h3FF0000000000000, 64'h3FF0000000000000, 64'hBFF0000000000000, 0, 64'h0, 4'b0},
		'{MAX_FINITE_BITS, MAX_FINITE_BITS, 64'h0, 0, 64'h0, 4'b0},
		'{64'hFFEFFFFFFFFFFFFF, 64'h3FF0000000000000, 64'hFFEFFFFFFFFFFFFF, 0, 64'h0, 4'b0},
		'{64'h0000000000000001, 64'h3FE0000000000000, 64'h0, 0, 64'h0, 4'b0},
		'{64'h0000000000000003, 64'h0000000000000005, 64'h8000000000000001, 0, 64'h0, 4'b0},
		'{64'h0010000000000000, 64'h3FEFFFFFFFFFFFFF, 64'h0, 0, 64'h0, 4'b0},
		'{64'h3FFFFFFFFFFFFFFF, 64'h3FFFFFFFFFFFFFFF, 64'hC00FFFFFFFFFFFFF, 0, 64'h0, 4'b0},
		'{64'h3FF0000000000001, 64'h3CA0000000000000, 64'h3FF0000000000000, 0, 64'h0, 4'b0},
		'{64'hFFFFFFFFFFFFFFFF, 64'h0, 64'h0, 1, QNAN_BITS, 4'b0000}
	};

	function automatic void unpack_operand(input logic [63:0] b, output logic [63:0] m,
			output int e);
		m = {12'd0, b[51:0]};
		if (b[62:52] != 11'd0) begin
			m[52] = 1'b1;
			e = int'(b[62:52]);
		end else begin
			e = 1;
			while (m != 0 && !m[52]) begin
				m = m << 1;
				e--;
			end
		end
	endfunction

	function automatic logic [127:0] low_mask(input int n);
		return (128'd1 << n) - 128'd1;
	endfunction

	function automatic logic [63:0] round_kept(input logic [127:0] r, input bit st,
			input int lsb, input bit neg, input logic [1:0] mode, output bit inex);
		logic [127:0] shifted;
		bit rb;
		bit sb;
		bit inc;
		if (lsb <= 0) begin
			shifted = r << (-lsb);
			rb = 1'b0;
			sb = st;
		end else begin
			shifted = r >> lsb;
			rb = (lsb - 1 < 128) ? r[lsb-1] : 1'b0;
			sb = st || ((r & low_mask(lsb - 1)) != 0);
		end
		case (mode)
			RM_RNE: inc = rb && (sb || shifted[0]);
			RM_RUP: inc = (rb || sb) && !neg;
			RM_RDN: inc = (rb || sb) && neg;
			default: inc = 1'b0;
		endcase
		inex = rb || sb;
		return shifted[63:0] + (inc ? 64'd1 : 64'd0);
	endfunction

	function automatic void fma_predict(input logic [63:0] x, input logic [63:0] y,
			input logic [63:0] z, input logic [1:0] mode, output fma_result_t r);
		bit xs, ys, zs, sp, sign, st, inex, ix, tiny, to_inf, inv;
		bit xnan, ynan, znan, xinf, yinf, zinf, xzero, yzero, zzero;
		int ea, eb, ez, eP, E, t, be, n;
		logic [63:0] ma, mb, mz, kept;
		logic [127:0] P, Z, R;
		logic [3:0] flags;
		xs = x[63]; ys = y[63]; zs = z[63];
		sp = xs ^ ys;
		xnan = x[62:52] == EXP_ALL_ONES && x[51:0] != 0;
		ynan = y[62:52] == EXP_ALL_ONES && y[51:0] != 0;
		znan = z[62:52] == EXP_ALL_ONES && z[51:0] != 0;
		xinf = x[62:52] == EXP_ALL_ONES && x[51:0] == 0;
		yinf = y[62:52] == EXP_ALL_ONES && y[51:0] == 0;
		zinf = z[62:52] == EXP_ALL_ONES && z[51:0] == 0;
		xzero = x[62:0] == 0;
		yzero = y[62:0] == 0;
		zzero = z[62:0] == 0;
		inv = (xnan && !x[51]) || (ynan && !y[51]) || (znan && !z[51]);
		flags = 4'b0;
		st = 1'b0;
		inex = 1'b0;
		if ((xinf && yzero) || (yinf && xzero)) inv = 1'b1;
		if (xnan || ynan || znan || inv) begin
			r.sum_bits = QNAN_BITS;
		end else if (xinf || yinf) begin
			if (zinf && zs != sp) begin
				inv = 1'b1;
				r.sum_bits = QNAN_BITS;
			end else begin
				r.sum_bits = {sp, INF_BITS[62:0]};
			end
		end else if (zinf) begin
			r.sum_bits = z;
		end else if (xzero || yzero) begin
			if (zzero) r.sum_bits = {(sp == zs) ? sp : (mode == RM_RDN), 63'd0};
			else r.sum_bits = z;
		end else begin
			unpack_operand(x, ma, ea);
			unpack_operand(y, mb, eb);
			P = ({64'd0, ma} * {64'd0, mb}) << 21;
			eP = ea + eb - 2150 - 21;
			sign = sp;
			if (zzero) begin
				R = P;
				E = eP;
			end else begin
				unpack_operand(z, mz, ez);
				Z = {64'd0, mz} << 74;
				E = ez - 1075 - 74;
				if (eP >= E) begin
					n = eP - E;
					if ((Z & low_mask(n)) != 0) st = 1'b1;
					Z = Z >> n;
					E = eP;
				end else begin
					n = E - eP;
					if ((P & low_mask(n)) != 0) st = 1'b1;
					P = P >> n;
				end
				if (sp == zs) begin
					R = P + Z;
				end else begin
					if (P < Z) begin
						R = Z - P;
						sign = zs;
					end else begin
						R = P - Z;
					end
					if (st && R != 0) R = R - 128'd1;
				end
			end
			t = -1;
			for (int i = 127; i >= 0; i--) begin
				if (t < 0 && R[i]) t = i;
			end
			if (t < 0) begin
				r.sum_bits = {mode == RM_RDN, 63'd0};
			end else begin
				be = t + E + 1023;
				if (be >= 1) begin
					kept = round_kept(R, st, t - 52, sign, mode, inex);
					if (kept[53]) begin
						kept = kept >> 1;
						be++;
					end
					if (be >= 2047) begin
						to_inf = mode == RM_RNE || (mode == RM_RUP && !sign)
							|| (mode == RM_RDN && sign);
						r.sum_bits = {sign, to_inf ? INF_BITS[62:0] : MAX_FINITE_BITS[62:0]};
						flags[FLAG_OVF] = 1'b1;
						inex = 1'b1;
					end else begin
						r.sum_bits = {sign, 11'(be), kept[51:0]};
					end
				end else begin
					tiny = 1'b1;
					kept = round_kept(R, st, -1074 - E, sign, mode, inex);
					if (be == 0) begin
						if (round_kept(R, st, t - 52, sign, mode, ix) >> 53) tiny = 1'b0;
					end
					r.sum_bits = {sign, 10'd0, kept[52:0]};
					if (inex && tiny) flags[FLAG_UNF] = 1'b1;
				end
				if (inex) flags[FLAG_INX] = 1'b1;
			end
		end
		if (inv) flags[FLAG_INV] = 1'b1;
		r.exception_flags = flags;
	endfunction

	function automatic logic [63:0] pick_operand();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: v[62:52] = 11'd0;
			1: v[62:52] = EXP_ALL_ONES;
			2: v[62:0] = 63'd0;
			3: v[62:52] = 11'($urandom_range(1, 60));
			4: v[62:52] = 11'($urandom_range(1980, 2046));
			5: v[51:0] = {$urandom_range(0, 1) ? 52'hFFFFFFFFFFFFF : 52'd0};
			default: v[62:52] = 11'($urandom_range(900, 1150));
		endcase
		return v;
	endfunction

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		fma_result_t want;
		int gap;
		if (!arst_n) begin
			out_res.ready <= 1'b0;
			stall_left <= 0;
		end else if (out_res.valid && out_res.ready) begin
			if (pending_sums.size() == 0) begin
				$error("result with no request outstanding: sum_bits %h", out_res.sum_bits);
				failures++;
			end else begin
				want = pending_sums.pop_front();
				if (out_res.sum_bits !== want.sum_bits) begin
					$error("sum_bits expected %h actual %h", want.sum_bits, out_res.sum_bits);
					failures++;
				end
				if (out_res.exception_flags !== want.exception_flags) begin
					$error("exception_flags expected %b actual %b", want.exception_flags,
						out_res.exception_flags);
					failures++;
				end
			end
			gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 14) : 0;
			stall_left <= gap;
			out_res.ready <= gap == 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_res.ready <= stall_left == 1;
		end else begin
			out_res.ready <= 1'b1;
		end
	end

	task automatic send_request(input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] c, input bit known, input fma_result_t typed, input bit busy);
		int gap;
		fma_result_t want;
		gap = busy ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_req.valid <= 1'b1;
		in_req.mul_a_bits <= a;
		in_req.mul_b_bits <= b;
		in_req.addend_bits <= c;
		@(posedge clk);
		while (!in_req.ready) @(posedge clk);
		if (known) want = typed;
		else fma_predict(a, b, c, active_mode, want);
		pending_sums.push_back(want);
	endtask

	task automatic write_rounding_mode(input logic [1:0] mode);
		in_req.valid <= 1'b0;
		@(posedge clk);
		while (pending_sums.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we <= 1'b0;
		active_mode = mode;
	endtask

	initial begin
		logic [1:0] mode_plan [0:4] = '{RM_RNE, RM_RTZ, RM_RUP, RM_RDN, RM_RNE};
		fma_result_t typed;
		logic [63:0] a, b, c;
		bit busy;
		int ea;
		failures = 0;
		active_mode = RM_RNE;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = RM_RNE;
		in_req.valid = 1'b0;
		in_req.mul_a_bits = 64'd0;
		in_req.mul_b_bits = 64'd0;
		in_req.addend_bits = 64'd0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < 5; p++) begin
			if (p > 0) write_rounding_mode(mode_plan[p]);
			busy = $urandom_range(0, 2) == 0;
			foreach (directed_vectors[i]) begin
				typed.sum_bits = directed_vectors[i].sum_bits;
				typed.exception_flags = directed_vectors[i].exception_flags;
				send_request(directed_vectors[i].a, directed_vectors[i].b,
					directed_vectors[i].c, directed_vectors[i].known, typed, busy);
			end
			for (int k = 0; k < (p == 4 ? 70 : RANDOM_PER_MODE); k++) begin
				if (k % 60 == 0) busy = $urandom_range(0, 3) == 0;
				a = pick_operand();
				b = pick_operand();
				c = pick_operand();
				if ($urandom_range(0, 3) == 0) begin
					// Addend close to minus the product, so that the sum cancels heavily.
					ea = int'(a[62:52]) + int'(b[62:52]) - 1023 + $urandom_range(0, 2) - 1;
					if (ea < 1) ea = 1;
					if (ea > 2046) ea = 2046;
					c = {~(a[63] ^ b[63]), 11'(ea), a[51:0] ^ 52'($urandom_range(0, 255))};
				end
				send_request(a, b, c, 1'b0, typed, busy);
			end
		end
		in_req.valid <= 1'b0;
		while (pending_sums.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

FILE: double_fused_multiply_add.f
rtl/dfma_pkg.sv
rtl/dfma_if.sv
rtl/double_fused_multiply_add.sv
tb/tb_top.sv
